// ===== design/double_ended_queue_core_macros.svh =====
// Assertion helpers shared by the deque design files.
`ifndef DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define DQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dq_pkg.sv =====
package dq_pkg;

  localparam int DataWidth    = 32;
  localparam int OpWidth      = 3;
  localparam int StatusWidth  = 2;
  localparam int DefaultDepth = 16;

  typedef enum logic [OpWidth-1:0] {
    OpPushFront = 3'd0,
    OpPushRear  = 3'd1,
    OpPopFront  = 3'd2,
    OpPopRear   = 3'd3,
    OpList      = 3'd4
  } dq_op_e;

  typedef enum logic [StatusWidth-1:0] {
    StatusOk        = 2'd0,
    StatusUnderflow = 2'd1,
    StatusFull      = 2'd2,
    StatusEmpty     = 2'd3
  } dq_status_e;

  typedef enum logic [1:0] {
    StIdle,
    StList,
    StRotate
  } dq_state_e;

  typedef enum logic [2:0] {
    CellHold,
    CellShiftR,
    CellFill,
    CellShiftL,
    CellRotL
  } dq_cell_op_e;

  typedef struct packed {
    dq_cell_op_e          op;
    logic [DataWidth-1:0] value;
  } dq_cell_cmd_t;

  typedef struct packed {
    logic [OpWidth-1:0]          operation;
    logic signed [DataWidth-1:0] value;
  } dq_in_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] item_value;
    logic [StatusWidth-1:0]      status;
    logic                        last;
  } dq_out_t;

endpackage

// ===== design/double_ended_queue_core.sv =====
// Channel   Direction  Handshake                   Beat
// request   in         start && !busy              req_i (operation, value)
// response  out        rsp_strobe_o, one cycle     rsp_o (item_value, status, last)
//
// Pushes, pop front, pop rear of a single entry and every underflow, full or empty
// status answer straight from idle. Pop rear of more entries keeps busy high while
// the chain rotates left until the rear entry reaches the head cell, then shifts it
// out. A list rotates the whole chain once and gives one beat per entry, front first.
// Reset clears the cell valid bits and the counters at once; no clearing pass.
// The response is registered and cannot be stalled; busy is high only while
// a list or a pop rear is walking the chain.
module double_ended_queue_core #(
  parameter int DEPTH = dq_pkg::DefaultDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  dq_pkg::dq_in_t req_i,
  output logic           rsp_strobe_o,
  output dq_pkg::dq_out_t rsp_o
);
  import dq_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  dq_state_e            state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      remain_q, remain_d;
  logic                 rsp_strobe_q, rsp_strobe_d;
  dq_out_t              rsp_q, rsp_d;
  dq_cell_cmd_t         cell_cmd;
  logic [DEPTH-1:0]     valid_w;
  logic [DataWidth-1:0] data_w [DEPTH];
  logic                 accept;
  logic                 is_full;
  logic                 is_empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DataWidth-1:0] prev_data;
    logic                 prev_valid;
    logic [DataWidth-1:0] next_data;
    logic                 next_valid;

    if (i == 0) begin : g_first
      assign prev_data  = cell_cmd.value;
      assign prev_valid = 1'b1;
    end else begin : g_inner_prev
      assign prev_data  = data_w[i-1];
      assign prev_valid = valid_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_data  = '0;
      assign next_valid = 1'b0;
    end else begin : g_inner_next
      assign next_data  = data_w[i+1];
      assign next_valid = valid_w[i+1];
    end

    dq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cell_cmd),
      .prev_data_i  (prev_data),
      .prev_valid_i (prev_valid),
      .next_data_i  (next_data),
      .next_valid_i (next_valid),
      .head_data_i  (data_w[0]),
      .data_o       (data_w[i]),
      .valid_o      (valid_w[i])
    );
  end

  assign busy     = (state_q != StIdle);
  assign accept   = start && !busy;
  assign is_full  = (count_q == CntW'(DEPTH));
  assign is_empty = (count_q == '0);

  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    remain_d       = remain_q;
    rsp_strobe_d   = 1'b0;
    rsp_d          = rsp_q;
    cell_cmd.op    = CellHold;
    cell_cmd.value = req_i.value;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (dq_op_e'(req_i.operation)) inside
            OpPushFront, OpPushRear: begin
              rsp_strobe_d     = 1'b1;
              rsp_d.item_value = '0;
              rsp_d.last       = 1'b1;
              if (is_full) begin
                rsp_d.status = StatusFull;
              end else begin
                rsp_d.status = StatusOk;
                count_d      = count_q + CntW'(1);
                cell_cmd.op  = (dq_op_e'(req_i.operation) == OpPushFront) ?
                               CellShiftR : CellFill;
              end
            end
            OpPopFront, OpPopRear: begin
              rsp_d.last = 1'b1;
              if (is_empty) begin
                rsp_strobe_d     = 1'b1;
                rsp_d.item_value = '0;
                rsp_d.status     = StatusUnderflow;
              end else if (dq_op_e'(req_i.operation) == OpPopFront ||
                           count_q == CntW'(1)) begin
                rsp_strobe_d     = 1'b1;
                rsp_d.item_value = $signed(data_w[0]);
                rsp_d.status     = StatusOk;
                count_d          = count_q - CntW'(1);
                cell_cmd.op      = CellShiftL;
              end else begin
                remain_d = count_q - CntW'(1);
                state_d  = StRotate;
              end
            end
            OpList: begin
              if (is_empty) begin
                rsp_strobe_d     = 1'b1;
                rsp_d.item_value = '0;
                rsp_d.status     = StatusEmpty;
                rsp_d.last       = 1'b1;
              end else begin
                remain_d = count_q;
                state_d  = StList;
              end
            end
            default: begin
              state_d = StIdle;
            end
          endcase
        end
      end
      StList: begin
        rsp_strobe_d     = 1'b1;
        rsp_d.item_value = $signed(data_w[0]);
        rsp_d.status     = StatusOk;
        rsp_d.last       = (remain_q == CntW'(1));
        cell_cmd.op      = CellRotL;
        remain_d         = remain_q - CntW'(1);
        if (remain_q == CntW'(1)) begin
          state_d = StIdle;
        end
      end
      StRotate: begin
        if (remain_q == '0) begin
          rsp_strobe_d     = 1'b1;
          rsp_d.item_value = $signed(data_w[0]);
          rsp_d.status     = StatusOk;
          rsp_d.last       = 1'b1;
          cell_cmd.op      = CellShiftL;
          count_d          = count_q - CntW'(1);
          state_d          = StIdle;
        end else begin
          cell_cmd.op = CellRotL;
          remain_d    = remain_q - CntW'(1);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      count_q      <= '0;
      remain_q     <= '0;
      rsp_strobe_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      remain_q     <= remain_d;
      rsp_strobe_q <= rsp_strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_strobe_o = rsp_strobe_q;
  assign rsp_o        = rsp_q;

`include "double_ended_queue_core_macros.svh"

  `DQ_ASSERT(a_count_range, count_q <= CntW'(DEPTH), "Entry count exceeds the depth.")
  `DQ_ASSERT(a_valid_count, $countones(valid_w) == int'(count_q), "Valid cells differ from count.")
  `DQ_ASSERT(a_valid_prefix, (valid_w & (valid_w + 1'b1)) == '0, "Valid cells are not a prefix.")
  `DQ_ASSERT_NEXT(a_list_continues, rsp_strobe_q && !rsp_q.last, rsp_strobe_q, "List beat missing.")
  `DQ_ASSERT_NEXT(a_rotate_ends, state_q == StRotate && remain_q == '0,
                  rsp_strobe_q && rsp_q.last, "Pop rear gave no result.")

endmodule

// ===== design/dq_cell.sv =====
module dq_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dq_pkg::dq_cell_cmd_t           cmd_i,
  input  logic [dq_pkg::DataWidth-1:0]   prev_data_i,
  input  logic                           prev_valid_i,
  input  logic [dq_pkg::DataWidth-1:0]   next_data_i,
  input  logic                           next_valid_i,
  input  logic [dq_pkg::DataWidth-1:0]   head_data_i,
  output logic [dq_pkg::DataWidth-1:0]   data_o,
  output logic                           valid_o
);
  import dq_pkg::*;

  logic [DataWidth-1:0] data_q, data_d;
  logic                 valid_q, valid_d;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    unique case (cmd_i.op)
      CellShiftR: begin
        data_d  = prev_data_i;
        valid_d = prev_valid_i;
      end
      CellFill: begin
        if (!valid_q && prev_valid_i) begin
          data_d  = cmd_i.value;
          valid_d = 1'b1;
        end
      end
      CellShiftL: begin
        data_d  = next_data_i;
        valid_d = next_valid_i;
      end
      CellRotL: begin
        if (valid_q) begin
          data_d = next_valid_i ? next_data_i : head_data_i;
        end
      end
      default: begin
        data_d  = data_q;
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;

endmodule
